/* rtl/spid_pkg.sv */
`timescale 1ns / 1ps
// spid_pkg: shared types and constants for the steering PID / PWM drive block.
// No dependencies; imported by steering_pid_pwm_drive.
package spid_pkg;

  localparam int POS_BITS       = 12;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int GAIN_W         = 16;
  localparam int TICK_W         = 32;
  localparam int DUTY_W         = 16;
  localparam int SUM_W          = 32;
  localparam int INTEG_W        = 48;
  localparam int ACC_W          = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD = 2'd3;

  typedef struct packed {
    logic [POS_BITS-1:0] target_pos;
    logic [POS_BITS-1:0] measured_pos;
    logic [TICK_W-1:0]   now_tick;
  } spid_in_t;

  typedef struct packed {
    logic                    turn_positive;
    logic [DUTY_W-1:0]       duty;
    logic signed [SUM_W-1:0] control_sum;
  } spid_out_t;

endpackage

/* rtl/steering_pid_pwm_drive.sv */
`timescale 1ns / 1ps
// steering_pid_pwm_drive: PID steering loop with saturated sum and PWM duty output.
// Depends on spid_pkg.
// Each item runs the multiplier for error times elapsed time, then the proportional, integral
// and derivative terms, then the derivative divide; the derivative is skipped when the elapsed
// tick count is zero. One item at a time; next accepted the cycle after the result is registered.
// Rate is set by the shared shift-add multiplier and the restoring divider, one bit a cycle.
// Synchronous active-low reset clears gains, state and handshakes; pwm_period resets to all ones.
module steering_pid_pwm_drive #(
  parameter int GAIN_FRAC_BITS = spid_pkg::GAIN_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  spid_pkg::spid_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output spid_pkg::spid_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [spid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spid_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import spid_pkg::*;

  localparam int ERR_W     = POS_BITS + 1;
  localparam int DERR_W    = POS_BITS + 2;
  localparam int MUL_STEPS = (ERR_W > GAIN_W) ? ERR_W : GAIN_W;
  localparam int NUM_W     = POS_BITS + GAIN_W;
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam int IS_W      = INTEG_W + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_INTEG, S_ADD, S_DIV, S_DADD, S_MAG, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_ERRDT, PH_PROP, PH_INTEG, PH_DERIV
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic signed [GAIN_W-1:0]  gain_prop_r, gain_prop_nxt;
  logic signed [GAIN_W-1:0]  gain_integ_r, gain_integ_nxt;
  logic signed [GAIN_W-1:0]  gain_deriv_r, gain_deriv_nxt;
  logic [DUTY_W-1:0]         pwm_period_r, pwm_period_nxt;

  logic signed [ERR_W-1:0]   last_error_r, last_error_nxt;
  logic [TICK_W-1:0]         last_tick_r, last_tick_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;

  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [DERR_W-1:0]  derr_r, derr_nxt;
  logic [TICK_W-1:0]         dt_r, dt_nxt;

  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic [ACC_W-1:0]          mcand_r, mcand_nxt;
  logic [MUL_STEPS-1:0]      mplier_r, mplier_nxt;
  logic                      neg_r, neg_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [ACC_W-1:0]   sum_r, sum_nxt;
  logic [TICK_W-1:0]         rem_r, rem_nxt;
  logic [NUM_W-1:0]          quo_r, quo_nxt;

  spid_out_t                 out_r, out_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // combinational helpers
  logic signed [ERR_W-1:0]   err_in;
  logic [ERR_W-1:0]          err_in_mag;
  logic [TICK_W-1:0]         dt_in;
  logic signed [DERR_W-1:0]  derr_in;
  logic [ERR_W-1:0]          err_mag;
  logic [DERR_W-1:0]         derr_mag;
  logic [INTEG_W-1:0]        integ_mag;
  logic [GAIN_W-1:0]         gp_mag, gi_mag, gd_mag;
  logic [ACC_W-1:0]          acc_step;
  logic signed [IS_W-1:0]    integ_ext, prod_ext, isum;
  logic [TICK_W:0]           trial, diff;
  logic [ACC_W-1:0]          m_full;
  logic [SUM_W-1:0]          m32;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    err_in     = ERR_W'(in_data.target_pos) - ERR_W'(in_data.measured_pos);
    err_in_mag = err_in[ERR_W-1] ? (~err_in + 1'b1) : err_in;
    dt_in      = in_data.now_tick - last_tick_r;
    derr_in    = DERR_W'(err_in) - DERR_W'(last_error_r);

    err_mag   = err_r[ERR_W-1] ? (~err_r + 1'b1) : err_r;
    derr_mag  = derr_r[DERR_W-1] ? (~derr_r + 1'b1) : derr_r;
    integ_mag = integ_r[INTEG_W-1] ? (~integ_r + 1'b1) : integ_r;
    gp_mag    = gain_prop_r[GAIN_W-1] ? (~gain_prop_r + 1'b1) : gain_prop_r;
    gi_mag    = gain_integ_r[GAIN_W-1] ? (~gain_integ_r + 1'b1) : gain_integ_r;
    gd_mag    = gain_deriv_r[GAIN_W-1] ? (~gain_deriv_r + 1'b1) : gain_deriv_r;

    acc_step  = mplier_r[0] ? (acc_r + mcand_r) : acc_r;

    integ_ext = IS_W'(integ_r);
    prod_ext  = IS_W'(acc_r[INTEG_W-1:0]);
    isum      = neg_r ? (integ_ext - prod_ext) : (integ_ext + prod_ext);

    trial = {rem_r, quo_r[NUM_W-1]};
    diff  = trial - (TICK_W+1)'(dt_r);

    m_full = acc_r >> GAIN_FRAC_BITS;
    if (neg_r) begin
      m32 = (m_full > ACC_W'(32'h8000_0000)) ? 32'h8000_0000 : m_full[SUM_W-1:0];
    end else begin
      m32 = (m_full > ACC_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : m_full[SUM_W-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    gain_prop_nxt  = gain_prop_r;
    gain_integ_nxt = gain_integ_r;
    gain_deriv_nxt = gain_deriv_r;
    pwm_period_nxt = pwm_period_r;
    last_error_nxt = last_error_r;
    last_tick_nxt  = last_tick_r;
    integ_nxt      = integ_r;
    err_nxt        = err_r;
    derr_nxt       = derr_r;
    dt_nxt         = dt_r;
    acc_nxt        = acc_r;
    mcand_nxt      = mcand_r;
    mplier_nxt     = mplier_r;
    neg_nxt        = neg_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_PROP:  gain_prop_nxt  = cfg_wdata;
        CFG_GAIN_INTEG: gain_integ_nxt = cfg_wdata;
        CFG_GAIN_DERIV: gain_deriv_nxt = cfg_wdata;
        CFG_PWM_PERIOD: pwm_period_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          err_nxt        = err_in;
          derr_nxt       = derr_in;
          dt_nxt         = dt_in;
          last_error_nxt = err_in;
          last_tick_nxt  = in_data.now_tick;
          sum_nxt        = '0;
          acc_nxt        = '0;
          mcand_nxt      = ACC_W'(dt_in);
          mplier_nxt     = MUL_STEPS'(err_in_mag);
          neg_nxt        = err_in[ERR_W-1];
          cnt_nxt        = CNT_W'(MUL_STEPS);
          phase_nxt      = PH_ERRDT;
          state_nxt      = S_MUL;
        end
      end
      S_MUL: begin
        acc_nxt    = acc_step;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          case (phase_r)
            PH_ERRDT:          state_nxt = S_INTEG;
            PH_PROP, PH_INTEG: state_nxt = S_ADD;
            PH_DERIV: begin
              quo_nxt   = acc_step[NUM_W-1:0];
              rem_nxt   = '0;
              cnt_nxt   = CNT_W'(NUM_W);
              state_nxt = S_DIV;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_INTEG: begin
        if (isum[IS_W-1:INTEG_W-1] != '0 && isum[IS_W-1:INTEG_W-1] != '1) begin
          integ_nxt = isum[IS_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                   : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
          integ_nxt = isum[INTEG_W-1:0];
        end
        acc_nxt    = '0;
        mcand_nxt  = ACC_W'(err_mag);
        mplier_nxt = MUL_STEPS'(gp_mag);
        neg_nxt    = err_r[ERR_W-1] ^ gain_prop_r[GAIN_W-1];
        cnt_nxt    = CNT_W'(MUL_STEPS);
        phase_nxt  = PH_PROP;
        state_nxt  = S_MUL;
      end
      S_ADD: begin
        sum_nxt = neg_r ? (sum_r - acc_r) : (sum_r + acc_r);
        acc_nxt = '0;
        cnt_nxt = CNT_W'(MUL_STEPS);
        case (phase_r)
          PH_PROP: begin
            mcand_nxt  = ACC_W'(integ_mag);
            mplier_nxt = MUL_STEPS'(gi_mag);
            neg_nxt    = integ_r[INTEG_W-1] ^ gain_integ_r[GAIN_W-1];
            phase_nxt  = PH_INTEG;
            state_nxt  = S_MUL;
          end
          default: begin
            if (dt_r != '0) begin
              mcand_nxt  = ACC_W'(derr_mag);
              mplier_nxt = MUL_STEPS'(gd_mag);
              neg_nxt    = derr_r[DERR_W-1] ^ gain_deriv_r[GAIN_W-1];
              phase_nxt  = PH_DERIV;
              state_nxt  = S_MUL;
            end else begin
              state_nxt = S_MAG;
            end
          end
        endcase
      end
      S_DIV: begin
        rem_nxt = diff[TICK_W] ? trial[TICK_W-1:0] : diff[TICK_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], ~diff[TICK_W]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_DADD;
        end
      end
      S_DADD: begin
        sum_nxt   = neg_r ? (sum_r - ACC_W'(quo_r)) : (sum_r + ACC_W'(quo_r));
        state_nxt = S_MAG;
      end
      S_MAG: begin
        acc_nxt   = sum_r[ACC_W-1] ? (~sum_r + 1'b1) : sum_r;
        neg_nxt   = sum_r[ACC_W-1];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.turn_positive = !neg_r && (m32 != '0);
          out_nxt.duty          = (m32 > SUM_W'(pwm_period_r)) ? pwm_period_r
                                                               : m32[DUTY_W-1:0];
          out_nxt.control_sum   = neg_r ? (~m32 + 1'b1) : m32;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_ERRDT;
      gain_prop_r  <= '0;
      gain_integ_r <= '0;
      gain_deriv_r <= '0;
      pwm_period_r <= '1;
      last_error_r <= '0;
      last_tick_r  <= '0;
      integ_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      gain_prop_r  <= gain_prop_nxt;
      gain_integ_r <= gain_integ_nxt;
      gain_deriv_r <= gain_deriv_nxt;
      pwm_period_r <= pwm_period_nxt;
      last_error_r <= last_error_nxt;
      last_tick_r  <= last_tick_nxt;
      integ_r      <= integ_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    err_r    <= err_nxt;
    derr_r   <= derr_nxt;
    dt_r     <= dt_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    neg_r    <= neg_nxt;
    cnt_r    <= cnt_nxt;
    sum_r    <= sum_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    out_r    <= out_nxt;
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for steering_pid_pwm_drive, with a PID/PWM predictor and a
// queue of expected drive results. Directed and random items, with and without random idling.
// Depends on spid_pkg and the steering_pid_pwm_drive RTL.
module testbench;
  import spid_pkg::*;

  localparam int     WATCHDOG_LIMIT = 3000;
  localparam int     END_DRAIN      = 120;
  localparam longint INTEG_MAX      = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_MIN      = -INTEG_MAX - 1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  spid_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  spid_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state and register copies
  logic signed [GAIN_W-1:0] kp_m, ki_m, kd_m;
  logic [DUTY_W-1:0]        period_m;
  longint                   last_err_m;
  logic [TICK_W-1:0]        last_tick_m;
  longint                   integ_m;

  spid_out_t drive_q[$];
  int        fail_count   = 0;
  int        idle_cycles  = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic [TICK_W-1:0] tick_now = '0;

  steering_pid_pwm_drive DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic spid_out_t pid_step(spid_in_t item);
    logic [TICK_W-1:0] dt;
    longint            err, dt_l, p_term, i_term, d_term, num, sum, shifted;
    longint unsigned   mag, dmag, quo;
    spid_out_t         res;
    dt   = item.now_tick - last_tick_m;
    dt_l = longint'(dt);
    err  = longint'(item.target_pos) - longint'(item.measured_pos);
    integ_m = integ_m + err * dt_l;
    if (integ_m > INTEG_MAX) integ_m = INTEG_MAX;
    if (integ_m < INTEG_MIN) integ_m = INTEG_MIN;
    p_term = err * longint'(kp_m);
    i_term = integ_m * longint'(ki_m);
    d_term = 0;
    if (dt != 0) begin
      num  = (err - last_err_m) * longint'(kd_m);
      dmag = (num < 0) ? -num : num;
      quo  = dmag / {32'd0, dt};
      d_term = (num < 0) ? -longint'(quo) : longint'(quo);
    end
    sum = p_term + i_term + d_term;
    mag = (sum < 0) ? -sum : sum;
    mag = mag >> GAIN_FRAC_BITS;
    if (sum < 0) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      shifted = -longint'(mag);
    end else begin
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      shifted = longint'(mag);
    end
    last_err_m  = err;
    last_tick_m = item.now_tick;
    res.turn_positive = (shifted > 0);
    res.duty          = (mag > period_m) ? period_m : mag[DUTY_W-1:0];
    res.control_sum   = shifted[SUM_W-1:0];
    return res;
  endfunction

  task automatic note_mismatch(input string what, input spid_out_t exp, input spid_out_t act);
    fail_count++;
    if (fail_count <= 10)
      $display("%s at %0t: expected turn=%0b duty=%0d sum=%0d, got turn=%0b duty=%0d sum=%0d",
               what, $time, exp.turn_positive, exp.duty, exp.control_sum,
               act.turn_positive, act.duty, act.control_sum);
  endtask

  // sample at the rising edge: register writes, result check, then prediction
  always @(posedge clk) begin
    spid_out_t exp;
    if (!rst_n) begin
      kp_m = '0;
      ki_m = '0;
      kd_m = '0;
      period_m = '1;
      last_err_m = 0;
      last_tick_m = '0;
      integ_m = 0;
      idle_cycles = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN_PROP:  kp_m = cfg_wdata;
          CFG_GAIN_INTEG: ki_m = cfg_wdata;
          CFG_GAIN_DERIV: kd_m = cfg_wdata;
          CFG_PWM_PERIOD: period_m = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          note_mismatch("unexpected result", '0, out_data);
        end else begin
          exp = drive_q.pop_front();
          if (out_data.turn_positive !== exp.turn_positive || out_data.duty !== exp.duty ||
              out_data.control_sum !== exp.control_sum)
            note_mismatch("mismatch", exp, out_data);
        end
      end
      if (in_valid && in_ready) drive_q.push_back(pid_step(in_data));
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  task automatic send_item(input logic [POS_BITS-1:0] tgt, input logic [POS_BITS-1:0] meas,
                           input logic [TICK_W-1:0] dt);
    spid_in_t item;
    tick_now = tick_now + dt;
    item.target_pos   = tgt;
    item.measured_pos = meas;
    item.now_tick     = tick_now;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle_block;
    @(negedge clk);
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_gains(input logic [15:0] kp, input logic [15:0] ki, input logic [15:0] kd,
                           input logic [15:0] period);
    settle_block();
    write_reg(CFG_GAIN_PROP, kp);
    write_reg(CFG_GAIN_INTEG, ki);
    write_reg(CFG_GAIN_DERIV, kd);
    write_reg(CFG_PWM_PERIOD, period);
  endtask

  function automatic logic [15:0] rand_gain();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(63)) ^ {16{$urandom_range(1) == 1}};
      5, 6: return 16'($urandom_range(1023)) ^ {16{$urandom_range(1) == 1}};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_period();
    int pick;
    pick = $urandom_range(5);
    case (pick)
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  // zero gains after reset; first item sees the raw timestamp as elapsed time
  task automatic test_reset_state;
    send_item(12'd4095, 12'd0, 32'h1234_5678);
    send_item(12'd0, 12'd4095, 32'd0);
  endtask

  task automatic test_proportional;
    set_gains(16'h0100, 16'h0000, 16'h0000, 16'hFFFF);
    send_item(12'd4095, 12'd0, 32'd1);
    send_item(12'd0, 12'd4095, 32'd1);
    set_gains(16'h7FFF, 16'h0000, 16'h0000, 16'd100);
    send_item(12'd4095, 12'd0, 32'd1);
    set_gains(16'h8000, 16'h0000, 16'h0000, 16'hFFFF);
    send_item(12'd4095, 12'd0, 32'd1);
  endtask

  // sub-unit sums truncate to zero; zero period forces zero duty
  task automatic test_small_sums;
    set_gains(16'h0001, 16'h0000, 16'h0000, 16'hFFFF);
    send_item(12'd255, 12'd0, 32'd2);
    send_item(12'd0, 12'd255, 32'd2);
    send_item(12'd0, 12'd1, 32'd2);
    set_gains(16'h0100, 16'h0000, 16'h0000, 16'h0000);
    send_item(12'd50, 12'd0, 32'd2);
  endtask

  // derivative with short and zero elapsed time
  task automatic test_derivative;
    set_gains(16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF);
    send_item(12'd4095, 12'd0, 32'd1);
    send_item(12'd0, 12'd4095, 32'd0);
    send_item(12'd0, 12'd4095, 32'd3);
    send_item(12'd4095, 12'd0, 32'd3);
    set_gains(16'h0000, 16'h0000, 16'h8000, 16'hFFFF);
    send_item(12'd0, 12'd4095, 32'd7);
  endtask

  // integral runs into its upper limit, sum saturates both ways
  task automatic test_windup;
    set_gains(16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF);
    repeat (9) send_item(12'd4095, 12'd0, 32'hFFFF_FFFF);
    set_gains(16'h0000, 16'h8000, 16'h0000, 16'hFFFF);
    send_item(12'd4095, 12'd0, 32'd0);
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent, len, kind, meas_i, tgt_i, k;
    logic up;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        // tracking run: position converges on a target, short tick steps
        len    = $urandom_range(12, 3);
        tgt_i  = $urandom_range(4095);
        meas_i = $urandom_range(4095);
        for (k = 0; k < len && sent < n_items; k++) begin
          if ($urandom_range(9) == 0) tgt_i = ($urandom_range(1) == 1) ? 4095 : 0;
          meas_i = meas_i + (tgt_i - meas_i) / 4 + int'($urandom_range(40)) - 20;
          if (meas_i < 0) meas_i = 0;
          if (meas_i > 4095) meas_i = 4095;
          case ($urandom_range(9))
            0: send_item(12'(tgt_i), 12'(meas_i), 32'd0);
            1: send_item(12'(tgt_i), 12'(meas_i), 32'($urandom_range(4, 1)));
            default: send_item(12'(tgt_i), 12'(meas_i), 32'($urandom_range(2000, 1)));
          endcase
          sent++;
        end
      end else if (kind < 90) begin
        // windup run: large error of one sign over long gaps
        up = 1'($urandom_range(1));
        for (k = 0; k < 20 && sent < n_items; k++) begin
          tgt_i  = up ? 4095 - int'($urandom_range(3)) : int'($urandom_range(3));
          meas_i = up ? int'($urandom_range(3)) : 4095 - int'($urandom_range(3));
          send_item(12'(tgt_i), 12'(meas_i), $urandom_range(32'hFFFF_FFFF, 32'h8000_0000));
          sent++;
        end
      end else begin
        send_item(12'($urandom), 12'($urandom),
                  ($urandom_range(1) == 1) ? 32'd0 : 32'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int mode;
    send_idle_pct = 36;
    recv_idle_pct = 47;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_proportional();
    test_small_sums();
    test_derivative();
    test_windup();
    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 47 : 0;
      recv_idle_pct = (mode == 0) ? 47 : (mode == 1) ? 36 : 0;
      repeat (3) begin
        set_gains(rand_gain(), ($urandom_range(2) == 0) ? 16'h0000 : rand_gain(),
                  rand_gain(), rand_period());
        test_random_traffic(150);
      end
    end
    settle_block();
    repeat (END_DRAIN) @(posedge clk);
    fail_count += drive_q.size();
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
